// ===== src/pco_pkg.sv =====
// ---------------------------------------------------------------------------
// pco_pkg: shared types and constants for the palette cursor overlay
// Item kinds, register indexes, control bit positions and stage payload.
// ---------------------------------------------------------------------------
package pco_pkg;

  // store geometry
  localparam int CURSOR_DEPTH    = 4096;
  localparam int CURSOR_AW       = 12;
  localparam int PALETTE_DEPTH   = 256;
  localparam int PALETTE_AW      = 8;
  localparam int MAX_CURSOR_SIDE = 64;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_PIXEL      = 2'd0;
  localparam logic [1:0] MODE_CURSOR_WR  = 2'd1;
  localparam logic [1:0] MODE_PALETTE_WR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_POINTER_X     = 3'd0;
  localparam logic [2:0] REG_POINTER_Y     = 3'd1;
  localparam logic [2:0] REG_HOTSPOT_X     = 3'd2;
  localparam logic [2:0] REG_HOTSPOT_Y     = 3'd3;
  localparam logic [2:0] REG_CURSOR_WIDTH  = 3'd4;
  localparam logic [2:0] REG_CURSOR_HEIGHT = 3'd5;
  localparam logic [2:0] REG_CLEAR_INDEX   = 3'd6;
  localparam logic [2:0] REG_CONTROL_BITS  = 3'd7;

  // control_bits positions
  localparam int CTRL_ENABLE    = 0;
  localparam int CTRL_PALETTE   = 1;
  localparam int CTRL_BOTTOM_UP = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // one input word as it travels down the pipeline
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  scene_red;
    logic [7:0]  scene_green;
    logic [7:0]  scene_blue;
    logic [11:0] write_address;
    logic [23:0] write_data;
  } item_t;

  // composited result word
  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } result_t;

endpackage

// ===== src/palette_cursor_overlay_top.sv =====
// ---------------------------------------------------------------------------
// palette_cursor_overlay_top: indexed hardware cursor over a pixel stream
// Scene pixels pass with alpha 255 or take the cursor colour inside the box;
// load words fill the cursor byte store and the colour palette.
// ---------------------------------------------------------------------------
//
// channel   direction  handshake           payload
// in_       slave      tvalid / tready     tdata 88b, tuser 2b (kind)
// out_      master     tvalid / tready     tdata 32b (red, green, blue, alpha)
// cfg_      slave      valid / ready       index 3b, data 13b
//
// one word accepted per clock while the skid entry is empty; a pixel result passes
// stages 1 to 5 and the output register; the cursor store read sets a stage, the palette read sets the next one
// reset clears valid bits and configuration registers; both stores hold junk until loaded
// a two-entry output (register plus skid) keeps input ready while the receiver first
// stalls; the whole pipeline holds while the skid entry is occupied
//
module palette_cursor_overlay_top (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata from bit 0: pixel_x 12, pixel_y 12, scene_red 8, scene_green 8,
  // scene_blue 8, write_address 12, write_data 24, zero pad 4
  input  logic [87:0] in_tdata,
  // in_tuser: mode 2
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata from bit 0: out_red 8, out_green 8, out_blue 8, out_alpha 8
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  // configuration registers
  logic [12:0] pointer_x_r, pointer_y_r;
  logic [5:0]  hotspot_x_r, hotspot_y_r;
  logic [6:0]  cursor_width_r, cursor_height_r;
  logic [7:0]  clear_index_r;
  logic [2:0]  control_bits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_x_r     <= '0;
      pointer_y_r     <= '0;
      hotspot_x_r     <= '0;
      hotspot_y_r     <= '0;
      cursor_width_r  <= '0;
      cursor_height_r <= '0;
      clear_index_r   <= '0;
      control_bits_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pco_pkg::REG_POINTER_X:     pointer_x_r     <= cfg_data;
        pco_pkg::REG_POINTER_Y:     pointer_y_r     <= cfg_data;
        pco_pkg::REG_HOTSPOT_X:     hotspot_x_r     <= cfg_data[5:0];
        pco_pkg::REG_HOTSPOT_Y:     hotspot_y_r     <= cfg_data[5:0];
        pco_pkg::REG_CURSOR_WIDTH:  cursor_width_r  <= cfg_data[6:0];
        pco_pkg::REG_CURSOR_HEIGHT: cursor_height_r <= cfg_data[6:0];
        pco_pkg::REG_CLEAR_INDEX:   clear_index_r   <= cfg_data[7:0];
        pco_pkg::REG_CONTROL_BITS:  control_bits_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // derived geometry; the box corner is read directly by stage 1,
  // stride and draw enable are registered since later stages use them
  logic [13:0] box_x, box_y;
  logic [7:0]  stride_r;
  logic        draw_ok_r;
  logic [7:0]  stride_nxt;
  logic [14:0] area_nxt;
  logic        draw_ok_nxt;

  always_comb begin
    box_x       = {pointer_x_r[12], pointer_x_r} - {8'd0, hotspot_x_r};
    box_y       = {pointer_y_r[12], pointer_y_r} - {8'd0, hotspot_y_r};
    stride_nxt = control_bits_r[pco_pkg::CTRL_BOTTOM_UP] ?
                 ((8'({1'b0, cursor_width_r}) + 8'd3) & 8'hFC) :
                 8'({1'b0, cursor_width_r});
    area_nxt    = 15'(cursor_height_r) * 15'(stride_nxt);
    draw_ok_nxt = control_bits_r[pco_pkg::CTRL_ENABLE] &&
                  (cursor_width_r != 7'd0) && (cursor_height_r != 7'd0) &&
                  (32'(cursor_width_r) <= pco_pkg::MAX_CURSOR_SIDE) &&
                  (32'(cursor_height_r) <= pco_pkg::MAX_CURSOR_SIDE) &&
                  (32'(area_nxt) <= pco_pkg::CURSOR_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_ok_r <= 1'b0;
    end else begin
      draw_ok_r <= draw_ok_nxt;
    end
    stride_r <= stride_nxt;
  end

  // pipeline advances unless the skid entry is occupied
  logic en;
  logic skid_full_r;
  assign en        = !skid_full_r;
  assign in_tready = en;

  pco_pkg::item_t in_item;
  assign in_item.mode          = in_tuser;
  assign in_item.pixel_x       = in_tdata[11:0];
  assign in_item.pixel_y       = in_tdata[23:12];
  assign in_item.scene_red     = in_tdata[31:24];
  assign in_item.scene_green   = in_tdata[39:32];
  assign in_item.scene_blue    = in_tdata[47:40];
  assign in_item.write_address = in_tdata[59:48];
  assign in_item.write_data    = in_tdata[83:60];

  // stage 1: position relative to the cursor box
  logic           s1_valid_r;
  pco_pkg::item_t s1_item_r;
  logic [14:0]    s1_col_r, s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
    if (en) begin
      s1_item_r <= in_item;
      s1_col_r  <= {3'd0, in_item.pixel_x} - {box_x[13], box_x};
      s1_row_r  <= {3'd0, in_item.pixel_y} - {box_y[13], box_y};
    end
  end

  // stage 2: inside test and stored row
  logic           s2_valid_r;
  pco_pkg::item_t s2_item_r;
  logic           s2_inside_r;
  logic [6:0]     s2_col_r, s2_srow_r;
  logic           s1_x_in, s1_y_in;
  logic [6:0]     s1_srow;

  always_comb begin
    s1_x_in = !s1_col_r[14] && (s1_col_r[13:0] < {7'd0, cursor_width_r});
    s1_y_in = !s1_row_r[14] && (s1_row_r[13:0] < {7'd0, cursor_height_r});
    s1_srow = control_bits_r[pco_pkg::CTRL_BOTTOM_UP] ?
              (cursor_height_r - 7'd1 - s1_row_r[6:0]) : s1_row_r[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en) begin
      s2_item_r   <= s1_item_r;
      s2_inside_r <= s1_x_in && s1_y_in && draw_ok_r;
      s2_col_r    <= s1_col_r[6:0];
      s2_srow_r   <= s1_srow;
    end
  end

  // stage 3: cursor byte address, row times stride plus column
  logic                          s3_valid_r;
  pco_pkg::item_t                s3_item_r;
  logic                          s3_inside_r;
  logic [pco_pkg::CURSOR_AW-1:0] s3_addr_r;
  logic [14:0]                   s2_sum;

  assign s2_sum = 15'(s2_srow_r) * 15'(stride_r) + 15'(s2_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
    if (en) begin
      s3_item_r   <= s2_item_r;
      s3_inside_r <= s2_inside_r;
      s3_addr_r   <= s2_sum[pco_pkg::CURSOR_AW-1:0];
    end
  end

  // stage 4: cursor store, loads and reads in stream order
  logic [7:0]     cursor_mem [pco_pkg::CURSOR_DEPTH];
  logic           s4_valid_r;
  pco_pkg::item_t s4_item_r;
  logic           s4_inside_r;
  logic [7:0]     s4_index_r;

  always_ff @(posedge clk) begin
    if (en && s3_valid_r && s3_item_r.mode == pco_pkg::MODE_CURSOR_WR) begin
      cursor_mem[s3_item_r.write_address] <= s3_item_r.write_data[7:0];
    end
    if (en) begin
      s4_index_r <= cursor_mem[s3_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
    if (en) begin
      s4_item_r   <= s3_item_r;
      s4_inside_r <= s3_inside_r;
    end
  end

  // stage 5: palette store and hit decision
  logic [23:0]    palette_mem [pco_pkg::PALETTE_DEPTH];
  logic           s5_valid_r;
  pco_pkg::item_t s5_item_r;
  logic           s5_hit_r;
  logic [7:0]     s5_index_r;
  logic [23:0]    s5_colour_r;

  always_ff @(posedge clk) begin
    if (en && s4_valid_r && s4_item_r.mode == pco_pkg::MODE_PALETTE_WR &&
        s4_item_r.write_address[11:pco_pkg::PALETTE_AW] == '0) begin
      palette_mem[s4_item_r.write_address[pco_pkg::PALETTE_AW-1:0]] <=
        s4_item_r.write_data;
    end
    if (en) begin
      s5_colour_r <= palette_mem[s4_index_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
    if (en) begin
      s5_item_r  <= s4_item_r;
      s5_hit_r   <= s4_inside_r && (s4_index_r != clear_index_r);
      s5_index_r <= s4_index_r;
    end
  end

  // colour select
  pco_pkg::result_t res;
  logic             res_valid;

  assign res_valid = s5_valid_r && (s5_item_r.mode == pco_pkg::MODE_PIXEL);

  always_comb begin
    res.out_alpha = pco_pkg::ALPHA_OPAQUE;
    if (!s5_hit_r) begin
      res.out_red   = s5_item_r.scene_red;
      res.out_green = s5_item_r.scene_green;
      res.out_blue  = s5_item_r.scene_blue;
    end else if (control_bits_r[pco_pkg::CTRL_PALETTE]) begin
      res.out_red   = s5_colour_r[7:0];
      res.out_green = s5_colour_r[15:8];
      res.out_blue  = s5_colour_r[23:16];
    end else begin
      res.out_red   = s5_index_r;
      res.out_green = s5_index_r;
      res.out_blue  = s5_index_r;
    end
  end

  // output register plus skid entry
  logic             out_valid_r, out_valid_nxt;
  pco_pkg::result_t out_data_r, out_data_nxt;
  logic             skid_full_nxt;
  pco_pkg::result_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_full_nxt = skid_full_r;
    skid_data_nxt = skid_data_r;
    if (out_valid_r && out_tready) begin
      if (skid_full_r) begin
        out_data_nxt  = skid_data_r;
        skid_full_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (en && res_valid) begin
      if (out_valid_r && !out_tready) begin
        skid_data_nxt = res;
        skid_full_nxt = 1'b1;
      end else begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid entry occupied while output register empty");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.out_alpha == pco_pkg::ALPHA_OPAQUE)
    else $error("result alpha not opaque");

  a_grey_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && s5_hit_r && !control_bits_r[pco_pkg::CTRL_PALETTE]) |->
    (res.out_red == res.out_green && res.out_green == res.out_blue))
    else $error("grey cursor pixel has unequal channels");

  a_skid_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(skid_full_r) && skid_full_r) |-> ($stable(s1_item_r) && $stable(s5_item_r)))
    else $error("pipeline moved while skid entry held");

endmodule

// ===== tb/tb_overlay_pkg.sv =====
// ---------------------------------------------------------------------------
// tb_overlay_pkg: expected-pixel tracking for the palette cursor overlay
// Keeps its own copy of the registers, the cursor bytes and the palette,
// composites every accepted scene pixel and checks results in order.
// ---------------------------------------------------------------------------
package tb_overlay_pkg;
  import pco_pkg::*;

  // kind that the block drops without a result
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // control register masks
  localparam logic [2:0] CTL_EN  = 3'(1 << CTRL_ENABLE);
  localparam logic [2:0] CTL_PAL = 3'(1 << CTRL_PALETTE);
  localparam logic [2:0] CTL_BU  = 3'(1 << CTRL_BOTTOM_UP);

  class overlay_scoreboard;
    logic signed [12:0] ptr_x, ptr_y;
    logic [5:0]         hot_x, hot_y;
    logic [6:0]         width, height;
    logic [7:0]         clear_idx;
    logic [2:0]         ctrl;
    logic [7:0]         cursor_mem [CURSOR_DEPTH];
    logic [23:0]        palette_mem [PALETTE_DEPTH];
    bit                 cursor_loaded [CURSOR_DEPTH];
    bit                 palette_loaded [PALETTE_DEPTH];
    result_t            expected_pixels [$];
    int                 errors, pixels, hits, loads;

    function new();
      foreach (cursor_loaded[i]) cursor_loaded[i] = 1'b0;
      foreach (palette_loaded[i]) palette_loaded[i] = 1'b0;
      ptr_x = '0; ptr_y = '0; hot_x = '0; hot_y = '0;
      width = '0; height = '0; clear_idx = '0; ctrl = '0;
      errors = 0; pixels = 0; hits = 0; loads = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        REG_POINTER_X:     ptr_x = val;
        REG_POINTER_Y:     ptr_y = val;
        REG_HOTSPOT_X:     hot_x = val[5:0];
        REG_HOTSPOT_Y:     hot_y = val[5:0];
        REG_CURSOR_WIDTH:  width = val[6:0];
        REG_CURSOR_HEIGHT: height = val[6:0];
        REG_CLEAR_INDEX:   clear_idx = val[7:0];
        REG_CONTROL_BITS:  ctrl = val[2:0];
        default: ;
      endcase
    endfunction

    // cursor byte address a pixel reads, or -1 when no cursor lookup happens
    function int cursor_addr(logic [11:0] px, logic [11:0] py);
      int w, h, stride, col, row, srow;
      w = int'(width);
      h = int'(height);
      if (!ctrl[CTRL_ENABLE] || w == 0 || h == 0 || w > MAX_CURSOR_SIDE ||
          h > MAX_CURSOR_SIDE)
        return -1;
      stride = ctrl[CTRL_BOTTOM_UP] ? ((w + 3) & ~3) : w;
      if (h * stride > CURSOR_DEPTH) return -1;
      col = int'(px) - (int'(ptr_x) - int'(hot_x));
      row = int'(py) - (int'(ptr_y) - int'(hot_y));
      if (col < 0 || col >= w || row < 0 || row >= h) return -1;
      srow = ctrl[CTRL_BOTTOM_UP] ? h - 1 - row : row;
      return (srow * stride + col) & (CURSOR_DEPTH - 1);
    endfunction

    // update the stores or composite one scene pixel
    function void note_word(logic [1:0] kind, logic [87:0] word);
      logic [11:0] wa;
      logic [23:0] wd;
      logic [7:0]  idx;
      result_t     res;
      int          a;
      wa = word[59:48];
      wd = word[83:60];
      case (kind)
        MODE_CURSOR_WR: begin
          cursor_mem[wa] = wd[7:0];
          cursor_loaded[wa] = 1'b1;
          loads++;
        end
        MODE_PALETTE_WR: begin
          if (wa < PALETTE_DEPTH) begin
            palette_mem[wa[7:0]] = wd;
            palette_loaded[wa[7:0]] = 1'b1;
          end
          loads++;
        end
        MODE_PIXEL: begin
          res.out_red   = word[31:24];
          res.out_green = word[39:32];
          res.out_blue  = word[47:40];
          res.out_alpha = ALPHA_OPAQUE;
          a = cursor_addr(word[11:0], word[23:12]);
          if (a >= 0) begin
            idx = cursor_mem[a];
            if (idx != clear_idx) begin
              hits++;
              if (ctrl[CTRL_PALETTE])
                {res.out_blue, res.out_green, res.out_red} = palette_mem[idx];
              else begin
                res.out_red = idx; res.out_green = idx; res.out_blue = idx;
              end
            end
          end
          pixels++;
          expected_pixels = {expected_pixels, res};
        end
        default: ;
      endcase
    endfunction

    // compare one result word with the oldest expected pixel
    function void check_pixel(logic [31:0] word);
      result_t want;
      string   names [4];
      names = '{"red", "green", "blue", "alpha"};
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel word %h", $time, word);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (word[8*i +: 8] !== want[8*i +: 8]) begin
          $display("%0t: %s mismatch, expected %h, actual %h", $time, names[i],
                   want[8*i +: 8], word[8*i +: 8]);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_palette_cursor_overlay_top.sv =====
// ---------------------------------------------------------------------------
// tb_palette_cursor_overlay_top: self-checking bench for the cursor overlay
// Drives scene pixels and load words in random bursts against a stalling
// receiver, sweeps register settings while idle and checks every pixel.
// ---------------------------------------------------------------------------
module tb_palette_cursor_overlay_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pco_pkg::*;
  import tb_overlay_pkg::*;

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int TARGET_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = MODE_PIXEL;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_POINTER_X;
  logic [12:0] cfg_data = '0;

  overlay_scoreboard sb;
  int items_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int cycles = 0;
  int stall_style = 0;
  int style_left = 0;
  int hold_left = 0;

  palette_cursor_overlay_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver stalls, style picked anew at random from four
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left <= $urandom_range(32, 256);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (cycles[1:0] != 2'd0);
      default: begin
        if (hold_left == 0) begin
          out_tready <= ~out_tready;
          hold_left <= $urandom_range(1, 8);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
  end

  // random word with zero pad, fields overwritten by the callers
  function automatic logic [87:0] filler();
    logic [87:0] w;
    w = {$urandom, $urandom, $urandom};
    w[87:84] = 4'd0;
    return w;
  endfunction

  function automatic logic [87:0] load_word(logic [11:0] addr, logic [23:0] data);
    logic [87:0] w;
    w = filler();
    w[59:48] = addr;
    w[83:60] = data;
    return w;
  endfunction

  function automatic logic [87:0] pixel_word(logic [11:0] px, logic [11:0] py,
                                             logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b);
    logic [87:0] w;
    w = filler();
    w[23:0]  = {py, px};
    w[47:24] = {b, g, r};
    return w;
  endfunction

  // cursor byte biased toward the transparent index
  function automatic logic [23:0] cursor_byte();
    logic [23:0] d;
    d = 24'($urandom);
    if ($urandom_range(0, 9) < 3) d[7:0] = sb.clear_idx;
    return d;
  endfunction

  function automatic logic [12:0] pick_pointer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 13'h1000;
    if (r < 8) return 13'h0FFF;
    if (r < 11) return 13'h1800;
    if (r < 14) return 13'd0;
    if (r < 90) return 13'($urandom_range(0, 4095));
    return 13'($urandom);
  endfunction

  function automatic logic [5:0] pick_hotspot();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 6'd63 : 6'd0;
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [6:0] pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 7'($urandom_range(1, 8));
    if (r < 80) return 7'($urandom_range(9, 64));
    if (r < 86) return 7'd0;
    if (r < 93) return 7'd64;
    return 7'($urandom_range(65, 127));
  endfunction

  // one input word, sender idles between bursts
  task automatic send_word(input logic [1:0] kind, input logic [87:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_tuser  <= kind;
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_word(kind, word);
    if (!(kind == MODE_UNUSED ||
          (kind == MODE_PALETTE_WR && word[59:48] >= PALETTE_DEPTH)))
      items_sent++;
  endtask

  // scene pixel, loading any cursor byte or palette entry it would read
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int         a;
    logic [7:0] idx;
    a = sb.cursor_addr(px, py);
    if (a >= 0) begin
      if (!sb.cursor_loaded[a]) send_word(MODE_CURSOR_WR, load_word(12'(a), cursor_byte()));
      idx = sb.cursor_mem[a];
      if (idx != sb.clear_idx && sb.ctrl[CTRL_PALETTE] && !sb.palette_loaded[idx])
        send_word(MODE_PALETTE_WR, load_word({4'd0, idx}, 24'($urandom)));
    end
    send_word(MODE_PIXEL, pixel_word(px, py, r, g, b));
  endtask

  task automatic wait_idle();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // full register setting, written only once the pipeline has drained
  task automatic apply_setting(input logic [12:0] px, input logic [12:0] py,
                               input logic [5:0] hx, input logic [5:0] hy,
                               input logic [6:0] w, input logic [6:0] h,
                               input logic [7:0] clr, input logic [2:0] ctl);
    in_tvalid <= 1'b0;
    wait_idle();
    write_reg(REG_POINTER_X, px);
    write_reg(REG_POINTER_Y, py);
    write_reg(REG_HOTSPOT_X, {7'($urandom), hx});
    write_reg(REG_HOTSPOT_Y, {7'($urandom), hy});
    write_reg(REG_CURSOR_WIDTH, {6'($urandom), w});
    write_reg(REG_CURSOR_HEIGHT, {6'($urandom), h});
    write_reg(REG_CLEAR_INDEX, {5'($urandom), clr});
    write_reg(REG_CONTROL_BITS, {10'($urandom), ctl});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // mostly pixels around the cursor box, some loads and noise
  task automatic random_item();
    int r, w, h, base_x, base_y, span;
    r = $urandom_range(0, 99);
    w = int'(sb.width);
    h = int'(sb.height);
    base_x = int'(sb.ptr_x) - int'(sb.hot_x);
    base_y = int'(sb.ptr_y) - int'(sb.hot_y);
    span = (w * h > 0) ? w * h + 4 : 64;
    if (r < 70)
      send_pixel(12'(base_x + int'($urandom_range(0, w + 3)) - 2),
                 12'(base_y + int'($urandom_range(0, h + 3)) - 2),
                 8'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 80)
      send_pixel(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 88)
      send_word(MODE_CURSOR_WR, load_word(12'($urandom_range(0, span - 1)), cursor_byte()));
    else if (r < 93)
      send_word(MODE_PALETTE_WR, load_word(12'($urandom_range(0, 255)), 24'($urandom)));
    else if (r < 95)
      send_word(MODE_UNUSED, filler());
    else if (r < 97)
      send_word(MODE_CURSOR_WR, load_word(12'($urandom), cursor_byte()));
    else
      send_word(MODE_PALETTE_WR,
                load_word(12'($urandom_range(PALETTE_DEPTH, 4095)), 24'($urandom)));
  endtask

  initial begin
    int dx [10];
    int dy [10];
    sb = new();
    dx = '{8, 12, 12, 8, 7, 13, 8, 12, 0, 4095};
    dy = '{17, 17, 20, 20, 17, 20, 16, 21, 0, 4095};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // palette box at columns 8..12, rows 17..20: corners, edges, extremes
    apply_setting(13'd10, 13'd20, 6'd2, 6'd3, 7'd5, 7'd4, 8'd0, CTL_EN | CTL_PAL);
    for (int i = 0; i < 10; i++)
      send_pixel(12'(dx[i]), 12'(dy[i]), (i == 9) ? 8'hFF : 8'h00,
                 (i == 9) ? 8'hFF : 8'h00, (i == 9) ? 8'hFF : 8'h00);
    // transparent index, fresh palette entry read right after its write
    send_word(MODE_CURSOR_WR, load_word(12'd0, 24'h000000));
    send_pixel(12'd8, 12'd17, 8'h12, 8'h34, 8'h56);
    send_word(MODE_PALETTE_WR, load_word(12'd5, 24'hA5C3E7));
    send_word(MODE_CURSOR_WR, load_word(12'd1, 24'hFFFF05));
    send_pixel(12'd9, 12'd17, 8'h00, 8'h00, 8'h00);
    // unused kind and out-of-range palette write are dropped
    send_word(MODE_UNUSED, filler());
    send_word(MODE_PALETTE_WR, load_word(12'hFFF, 24'hFFFFFF));

    // bottom-up padded grey cursor hanging off the top-left corner
    apply_setting(13'h1FFF, 13'h1FFF, 6'd0, 6'd0, 7'd3, 7'd2, 8'd255, CTL_EN | CTL_BU);
    send_pixel(12'd0, 12'd0, 8'h11, 8'h22, 8'h33);
    send_pixel(12'd1, 12'd0, 8'h44, 8'h55, 8'h66);
    send_pixel(12'd2, 12'd0, 8'h77, 8'h88, 8'h99);
    send_pixel(12'd0, 12'd1, 8'hAA, 8'hBB, 8'hCC);

    // oversized cursor with extreme registers passes pixels through
    apply_setting(13'h0FFF, 13'h1000, 6'd63, 6'd63, 7'd65, 7'd127, 8'd255, 3'b111);
    send_pixel(12'd0, 12'd0, 8'h01, 8'h02, 8'h03);
    send_pixel(12'hFFF, 12'hFFF, 8'hFE, 8'hFD, 8'hFC);

    // random settings and traffic
    while (items_sent < TARGET_ITEMS) begin
      apply_setting(pick_pointer(), pick_pointer(), pick_hotspot(), pick_hotspot(),
                    pick_side(), pick_side(),
                    ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                : 8'($urandom),
                    3'($urandom_range(0, 7)) | (($urandom_range(0, 3) != 0) ? CTL_EN : 3'd0));
      for (int k = $urandom_range(30, 120); k > 0 && items_sent < TARGET_ITEMS; k--)
        random_item();
    end

    in_tvalid <= 1'b0;
    wait_idle();
    $display("covered %0d scene pixels (%0d drawn from the cursor) and %0d load words",
             sb.pixels, sb.hits, sb.loads);
    $display("over %0d register settings with random sender gaps and receiver stalls",
             settings_used);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pco_pkg.sv
src/palette_cursor_overlay_top.sv
tb/tb_overlay_pkg.sv
tb/tb_palette_cursor_overlay_top.sv
